/* src/ttrd_pkg.sv */
// ----------------------------------------------------------------------------
// ttrd_pkg
// Shared types and constants of the time tag record decoder: register
// indexes, mode codes, record field widths and the decoded record struct.
// ----------------------------------------------------------------------------
package ttrd_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_KIND = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMING_MODE = 1'd1;

  // Record format codes.
  localparam logic KIND_CH6 = 1'b0;
  localparam logic KIND_CH4 = 1'b1;

  // Timing mode codes.
  localparam logic [1:0] MODE_T2 = 2'd2;
  localparam logic [1:0] MODE_T3 = 2'd3;

  // Reset values of the configuration registers.
  localparam logic       DEVICE_KIND_RESET = KIND_CH6;
  localparam logic [1:0] TIMING_MODE_RESET = MODE_T2;

  // Widths of the payload.
  localparam int WORD_W    = 32;
  localparam int WIDE_W    = 64;
  localparam int CHANNEL_W = 6;
  localparam int TFIELD_W  = 28;  // widest time field (four-bit-channel T2)
  localparam int SFIELD_W  = 16;  // widest sync field (four-bit-channel T3)

  // Special channel codes.
  localparam logic [5:0] CH6_OVERFLOW = 6'd63;
  localparam logic [3:0] CH4_OVERFLOW = 4'd15;
  localparam logic [3:0] CH4_LAST_T2  = 4'd4;
  localparam logic [3:0] CH4_FIRST_T3 = 4'd1;
  localparam logic [3:0] CH4_LAST_T3  = 4'd4;

  // Fixed overflow periods of the four-bit-channel format.
  localparam logic [WIDE_W-1:0] OVF_PERIOD_CH4_T2 = 64'd210698240;
  localparam logic [WIDE_W-1:0] OVF_PERIOD_CH4_T3 = 64'd65536;

  // One record after field decode.
  typedef struct packed {
    logic                  is_photon;
    logic                  is_overflow;
    logic                  abs_time;     // T2: time field is relative to the base
    logic [TFIELD_W-1:0]   time_field;
    logic [SFIELD_W-1:0]   sync_field;
    logic [CHANNEL_W-1:0]  channel;
    logic [WIDE_W-1:0]     ovf_incr;
  } decode_t;

endpackage

/* src/ttrd_decode.sv */
// ----------------------------------------------------------------------------
// ttrd_decode
// Field decode of one raw record: classifies it as photon, overflow or
// ignored, extracts the time, sync and channel fields and forms the
// overflow increment.
// ----------------------------------------------------------------------------
module ttrd_decode (
  input  logic [ttrd_pkg::WORD_W-1:0] word,
  input  logic                        device_kind,
  input  logic [1:0]                  timing_mode,
  output ttrd_pkg::decode_t           dec
);
  import ttrd_pkg::*;

  logic        special;
  logic [5:0]  ch6;
  logic [3:0]  ch4;
  logic [24:0] t6_t2;
  logic [14:0] t6_t3;
  logic [9:0]  s6_t3;
  logic [24:0] n6_t2;
  logic [9:0]  n6_t3;

  // Raw fields of both formats.
  assign special = word[31];
  assign ch6     = word[30:25];
  assign ch4     = word[31:28];
  assign t6_t2   = word[24:0];
  assign t6_t3   = word[24:10];
  assign s6_t3   = word[9:0];

  // Overflow counts, where a count of zero counts as one.
  assign n6_t2 = (t6_t2 == '0) ? 25'd1 : t6_t2;
  assign n6_t3 = (s6_t3 == '0) ? 10'd1 : s6_t3;

  // Classify the record and select its fields.
  always_comb begin
    dec = '0;
    if (device_kind == KIND_CH6) begin
      dec.channel = ch6;
      unique case (timing_mode)
        MODE_T2: begin
          dec.abs_time    = 1'b1;
          dec.time_field  = {3'b0, t6_t2};
          dec.is_photon   = !special;
          dec.is_overflow = special && (ch6 == CH6_OVERFLOW);
          dec.ovf_incr    = {14'b0, n6_t2, 25'b0};
        end
        MODE_T3: begin
          dec.time_field  = {13'b0, t6_t3};
          dec.sync_field  = {6'b0, s6_t3};
          dec.is_photon   = !special;
          dec.is_overflow = special && (ch6 == CH6_OVERFLOW);
          dec.ovf_incr    = {44'b0, n6_t3, 10'b0};
        end
        default: begin
          dec = '0;
        end
      endcase
    end else begin
      dec.channel = {2'b0, ch4};
      unique case (timing_mode)
        MODE_T2: begin
          dec.abs_time    = 1'b1;
          dec.time_field  = word[27:0];
          dec.is_photon   = (ch4 <= CH4_LAST_T2);
          dec.is_overflow = (ch4 == CH4_OVERFLOW) && (word[3:0] == 4'd0);
          dec.ovf_incr    = OVF_PERIOD_CH4_T2;
        end
        MODE_T3: begin
          dec.time_field  = {16'b0, word[27:16]};
          dec.sync_field  = word[15:0];
          dec.is_photon   = (ch4 >= CH4_FIRST_T3) && (ch4 <= CH4_LAST_T3);
          dec.is_overflow = (ch4 == CH4_OVERFLOW) && (word[19:16] == 4'd0);
          dec.ovf_incr    = OVF_PERIOD_CH4_T3;
        end
        default: begin
          dec = '0;
        end
      endcase
    end
  end

endmodule

/* src/ttrd_accum.sv */
// ----------------------------------------------------------------------------
// ttrd_accum
// Running overflow base and photon counter, and the result register with
// its output handshake. One decoded record is applied per load.
// ----------------------------------------------------------------------------
module ttrd_accum (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  ttrd_pkg::decode_t              dec,
  input  logic                           last,
  output logic                           load_ok,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           is_photon,
  output logic [ttrd_pkg::WIDE_W-1:0]    time_value,
  output logic [ttrd_pkg::WIDE_W-1:0]    sync_count,
  output logic [ttrd_pkg::CHANNEL_W-1:0] channel_number,
  output logic [ttrd_pkg::WIDE_W-1:0]    photons_in_buffer,
  output logic [ttrd_pkg::WIDE_W-1:0]    overflow_total
);
  import ttrd_pkg::*;

  logic [WIDE_W-1:0] overflow_base;
  logic [WIDE_W-1:0] overflow_base_next;
  logic [WIDE_W-1:0] photon_counter;
  logic [WIDE_W-1:0] count_incr;
  logic [WIDE_W-1:0] time_next;
  logic [WIDE_W-1:0] sync_next;

  // The result register can take a new record when empty or being drained.
  assign load_ok = !out_valid || !out_stall;

  // State updates and result values of the record being loaded.
  always_comb begin
    overflow_base_next = overflow_base + (dec.is_overflow ? dec.ovf_incr : '0);
    count_incr         = photon_counter + {{(WIDE_W-1){1'b0}}, dec.is_photon};
    time_next          = '0;
    sync_next          = '0;
    if (dec.is_photon) begin
      if (dec.abs_time) begin
        time_next = overflow_base + {{(WIDE_W-TFIELD_W){1'b0}}, dec.time_field};
      end else begin
        time_next = {{(WIDE_W-TFIELD_W){1'b0}}, dec.time_field};
        sync_next = overflow_base + {{(WIDE_W-SFIELD_W){1'b0}}, dec.sync_field};
      end
    end
  end

  // Control: result valid and running state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      overflow_base  <= '0;
      photon_counter <= '0;
    end else begin
      if (load) begin
        out_valid      <= 1'b1;
        overflow_base  <= overflow_base_next;
        photon_counter <= last ? '0 : count_incr;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      is_photon         <= dec.is_photon;
      time_value        <= time_next;
      sync_count        <= sync_next;
      channel_number    <= dec.is_photon ? dec.channel : '0;
      photons_in_buffer <= count_incr;
      overflow_total    <= overflow_base_next;
    end
  end

  // The base only moves when a record is loaded.
  a_base_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(overflow_base))
    else $error("overflow base changed without a record");

  // The last record of a buffer restarts the photon count.
  a_buffer_restart: assert property (@(posedge clk) disable iff (rst)
    load && last |=> photon_counter == '0)
    else $error("photon counter did not restart after last record");

  // A non-photon result carries no time, sync or channel.
  a_nonphoton_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_photon |->
      time_value == '0 && sync_count == '0 && channel_number == '0)
    else $error("non-photon result with nonzero fields");

  // The reported base always matches the running base.
  a_total_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> overflow_total == overflow_base)
    else $error("overflow total differs from running base");

endmodule

/* src/time_tag_record_decoder_unit.sv */
// ----------------------------------------------------------------------------
// time_tag_record_decoder_unit
// Decoder for 32-bit time-tagged photon records in two formats, each in
// absolute (T2) or sync-relative (T3) timing mode.
//
// Usage:
//   Records enter on the in channel (in_valid / in_stall, record_word and
//   last_record) and one result leaves on the out channel (out_valid /
//   out_stall) for every record, photon or not. A transfer takes place at a
//   rising edge with valid high and stall low.
//   A record taken on the in channel lands in the input register; its result
//   is registered in the result register once that register can take it, and
//   out_valid rises with it.
//   Throughput: one record per cycle while the receiver does not stall. The
//   figure is set by the overflow base loop: one 64-bit add of the base per record.
//   When the receiver stalls, the result register holds its result and the
//   input register takes one more record, after which in_stall rises.
//   Configuration (format and timing mode) is written on cfg_write /
//   cfg_index / cfg_data while no record is in flight.
//   Reset is synchronous: both registers empty, overflow base and photon
//   count cleared, format six-bit-channel, timing mode T2.
// ----------------------------------------------------------------------------
module time_tag_record_decoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ttrd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ttrd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ttrd_pkg::WORD_W-1:0]      record_word,
  input  logic                             last_record,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             is_photon,
  output logic [ttrd_pkg::WIDE_W-1:0]      time_value,
  output logic [ttrd_pkg::WIDE_W-1:0]      sync_count,
  output logic [ttrd_pkg::CHANNEL_W-1:0]   channel_number,
  output logic [ttrd_pkg::WIDE_W-1:0]      photons_in_buffer,
  output logic [ttrd_pkg::WIDE_W-1:0]      overflow_total
);
  import ttrd_pkg::*;

  logic              device_kind;
  logic [1:0]        timing_mode;
  logic              hold_valid;
  logic [WORD_W-1:0] hold_word;
  logic              hold_last;
  logic              load_ok;
  logic              advance;
  logic              take;
  decode_t           dec;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_kind <= DEVICE_KIND_RESET;
      timing_mode <= TIMING_MODE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEVICE_KIND: device_kind <= cfg_data[0];
        CFG_TIMING_MODE: timing_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Input handshake: the held record moves on when the result register is free.
  assign advance  = hold_valid && load_ok;
  assign in_stall = hold_valid && !load_ok;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_word <= record_word;
      hold_last <= last_record;
    end
  end

  // Field decode of the held record.
  ttrd_decode u_decode (
    .word        (hold_word),
    .device_kind (device_kind),
    .timing_mode (timing_mode),
    .dec         (dec)
  );

  // Running state and result register.
  ttrd_accum u_accum (
    .clk               (clk),
    .rst               (rst),
    .load              (advance),
    .dec               (dec),
    .last              (hold_last),
    .load_ok           (load_ok),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .is_photon         (is_photon),
    .time_value        (time_value),
    .sync_count        (sync_count),
    .channel_number    (channel_number),
    .photons_in_buffer (photons_in_buffer),
    .overflow_total    (overflow_total)
  );

  // Stall on the input only while both registers are full and blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid && out_valid && out_stall)
    else $error("input stalled with room downstream");

  // A held record that is not passed on stays in the input register.
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid && $stable(hold_word))
    else $error("held record lost under stall");

  // Every record passed on appears as a result at the next edge.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("record passed on without a result");

endmodule

/* tb/time_tag_record_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_tag_record_decoder_unit_tb
// Self-checking bench for the time tag record decoder. A short table of
// directed records and register writes comes first, then a run of long
// overflow records that moves the overflow base in large steps, then random
// records under several format and timing mode settings. Every record is
// decoded by a model in the bench, and each result transfer is checked field
// by field.
// ----------------------------------------------------------------------------
module time_tag_record_decoder_unit_tb;
  import ttrd_pkg::*;

  // Timing modes in which the decoder decodes no record: each result is non-photon.
  localparam logic [1:0] MODE_IDLE0 = 2'd0;
  localparam logic [1:0] MODE_IDLE1 = 2'd1;

  // Overflow periods of the six-bit-channel format, scaled by the count field.
  localparam logic [WIDE_W-1:0] CH6_T2_PERIOD = 64'd33554432;
  localparam logic [WIDE_W-1:0] CH6_T3_PERIOD = 64'd1024;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 10;
  localparam int LONG_OVF_RECORDS = 40;
  localparam int NUM_DIRECTED     = 31;
  localparam int NUM_PHASES       = 10;

  typedef struct packed {
    logic              is_photon;
    logic [WIDE_W-1:0] time_value;
    logic [WIDE_W-1:0] sync_count;
    logic [5:0]        channel_number;
    logic [WIDE_W-1:0] photons_in_buffer;
    logic [WIDE_W-1:0] overflow_total;
  } record_result_t;

  typedef enum logic [1:0] {ROW_RECORD, ROW_SET_KIND, ROW_SET_MODE} row_op_e;

  typedef struct {
    row_op_e        op;
    logic [31:0]    word;   // record, or register data in the low bits
    logic           last;
    logic           typed;  // use the result typed in the row
    record_result_t want;
  } stim_row_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [WORD_W-1:0]      record_word = '0;
  logic                   last_record = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   is_photon;
  logic [WIDE_W-1:0]      time_value;
  logic [WIDE_W-1:0]      sync_count;
  logic [CHANNEL_W-1:0]   channel_number;
  logic [WIDE_W-1:0]      photons_in_buffer;
  logic [WIDE_W-1:0]      overflow_total;

  // Decoder state as the bench sees it.
  logic              dev_kind = DEVICE_KIND_RESET;
  logic [1:0]        time_mode = TIMING_MODE_RESET;
  logic [WIDE_W-1:0] ovf_base = '0;
  logic [WIDE_W-1:0] photon_cnt = '0;

  record_result_t pending_results [$];
  int             error_count = 0;
  int             burst_left = 0;
  int             idle_cycles = 0;
  int             stall_left = 0;
  stim_row_t      directed_rows [NUM_DIRECTED];

  time_tag_record_decoder_unit dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .record_word       (record_word),
    .last_record       (last_record),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .is_photon         (is_photon),
    .time_value        (time_value),
    .sync_count        (sync_count),
    .channel_number    (channel_number),
    .photons_in_buffer (photons_in_buffer),
    .overflow_total    (overflow_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Decode one record, advance the overflow base and photon count, and
  // return the result the block should give for it.
  function automatic record_result_t decode_record(input logic [31:0] w, input logic last);
    record_result_t r;
    logic [WIDE_W-1:0] n;
    r = '0;
    if (dev_kind == KIND_CH6) begin
      if (time_mode == MODE_T2) begin
        if (!w[31]) begin
          r.is_photon = 1'b1;
          r.time_value = ovf_base + 64'(w[24:0]);
          r.channel_number = w[30:25];
        end else if (w[30:25] == CH6_OVERFLOW) begin
          n = (w[24:0] == '0) ? 64'd1 : 64'(w[24:0]);
          ovf_base = ovf_base + CH6_T2_PERIOD * n;
        end
      end else if (time_mode == MODE_T3) begin
        if (!w[31]) begin
          r.is_photon = 1'b1;
          r.time_value = 64'(w[24:10]);
          r.sync_count = ovf_base + 64'(w[9:0]);
          r.channel_number = w[30:25];
        end else if (w[30:25] == CH6_OVERFLOW) begin
          n = (w[9:0] == '0) ? 64'd1 : 64'(w[9:0]);
          ovf_base = ovf_base + CH6_T3_PERIOD * n;
        end
      end
    end else begin
      if (time_mode == MODE_T2) begin
        if (w[31:28] <= CH4_LAST_T2) begin
          r.is_photon = 1'b1;
          r.time_value = ovf_base + 64'(w[27:0]);
          r.channel_number = {2'b00, w[31:28]};
        end else if (w[31:28] == CH4_OVERFLOW && w[3:0] == 4'd0) begin
          ovf_base = ovf_base + OVF_PERIOD_CH4_T2;
        end
      end else if (time_mode == MODE_T3) begin
        if (w[31:28] >= CH4_FIRST_T3 && w[31:28] <= CH4_LAST_T3) begin
          r.is_photon = 1'b1;
          r.time_value = 64'(w[27:16]);
          r.sync_count = ovf_base + 64'(w[15:0]);
          r.channel_number = {2'b00, w[31:28]};
        end else if (w[31:28] == CH4_OVERFLOW && w[19:16] == 4'd0) begin
          ovf_base = ovf_base + OVF_PERIOD_CH4_T3;
        end
      end
    end
    if (r.is_photon) photon_cnt = photon_cnt + 64'd1;
    r.photons_in_buffer = photon_cnt;
    r.overflow_total = ovf_base;
    // The count restarts only after the last record's result is formed.
    if (last) photon_cnt = '0;
    return r;
  endfunction

  // Random record for the current format and mode: mostly photons and
  // overflows, with markers, near misses and unconstrained words mixed in.
  function automatic logic [31:0] pick_record();
    logic [31:0] w;
    int unsigned sel;
    w = $urandom();
    sel = $urandom_range(0, 99);
    if (sel >= 85) return w;
    if (dev_kind == KIND_CH6) begin
      if (sel < 50) begin
        w[31] = 1'b0;
      end else if (sel < 75) begin
        w[31:25] = {1'b1, CH6_OVERFLOW};
        // A zero count field still counts as one period.
        if (sel < 58) begin
          if (time_mode == MODE_T3) w[9:0] = '0;
          else w[24:0] = '0;
        end
      end else begin
        w[31] = 1'b1;
        if (w[30:25] == CH6_OVERFLOW) w[25] = 1'b0;
      end
    end else begin
      if (sel < 50) begin
        w[31:28] = (time_mode == MODE_T3) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(0, 4));
      end else if (sel < 70) begin
        w[31:28] = CH4_OVERFLOW;
        if (time_mode == MODE_T3) w[19:16] = 4'd0;
        else w[3:0] = 4'd0;
      end else if (sel < 78) begin
        w[31:28] = CH4_OVERFLOW;
      end else begin
        w[31:28] = 4'($urandom_range(0, 14));
      end
    end
    return w;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      error_count++;
    end
  endfunction

  // Offer one record; the sender runs in bursts with random gaps between.
  task automatic send_record(input logic [31:0] w, input logic last, input logic typed,
                             input record_result_t want);
    record_result_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    record_word <= w;
    last_record <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    r = decode_record(w, last);
    pending_results.push_back(typed ? want : r);
  endtask

  // Register write with nothing in flight.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_DEVICE_KIND) dev_kind = data[0];
    else time_mode = data;
  endtask

  // Directed table: extremes after reset with typed results, then each
  // format and mode, overflow and ignored records, and the undecoded modes.
  initial begin
    directed_rows = '{
      '{ROW_RECORD, 32'h0000_0000, 1'b0, 1'b1,
        '{1'b1, 64'd0, 64'd0, 6'd0, 64'd1, 64'd0}},
      '{ROW_RECORD, 32'h7FFF_FFFF, 1'b0, 1'b1,
        '{1'b1, 64'd33554431, 64'd0, 6'd63, 64'd2, 64'd0}},
      '{ROW_RECORD, 32'hFE00_0000, 1'b0, 1'b1,
        '{1'b0, 64'd0, 64'd0, 6'd0, 64'd2, 64'd33554432}},
      '{ROW_RECORD, 32'hFFFF_FFFF, 1'b1, 1'b1,
        '{1'b0, 64'd0, 64'd0, 6'd0, 64'd2, 64'd1125899906842624}},
      '{ROW_RECORD, 32'h8000_0001, 1'b0, 1'b1,
        '{1'b0, 64'd0, 64'd0, 6'd0, 64'd0, 64'd1125899906842624}},
      '{ROW_SET_MODE, 32'(MODE_T3), 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'hFE00_0000, 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'hFE00_03FF, 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'h7FFF_FFFF, 1'b1, 1'b0, '0},
      '{ROW_RECORD, 32'h8200_0000, 1'b0, 1'b0, '0},
      '{ROW_SET_KIND, 32'(KIND_CH4), 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'h1000_0000, 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'h4FFF_FFFF, 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'h0000_1234, 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'hF000_FFFF, 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'hF001_0000, 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'h5000_0000, 1'b1, 1'b0, '0},
      '{ROW_SET_MODE, 32'(MODE_T2), 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'h4FFF_FFFF, 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'hF000_0000, 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'hF000_0001, 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'h8000_0000, 1'b1, 1'b0, '0},
      '{ROW_SET_MODE, 32'(MODE_IDLE0), 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{ROW_SET_MODE, 32'(MODE_IDLE1), 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
      // Upper data bit set: only bit 0 selects the format.
      '{ROW_SET_KIND, 32'h0000_0002, 1'b0, 1'b0, '0},
      '{ROW_SET_MODE, 32'(MODE_T2), 1'b0, 1'b0, '0},
      '{ROW_RECORD, 32'h7E00_0000, 1'b0, 1'b0, '0}
    };
  end

  // Main sequence.
  initial begin
    logic       phase_kind [NUM_PHASES];
    logic [1:0] phase_mode [NUM_PHASES];
    int         phase_len;
    logic [31:0] w;

    phase_kind = '{KIND_CH6, KIND_CH6, KIND_CH4, KIND_CH4, KIND_CH4,
                   KIND_CH6, KIND_CH6, KIND_CH4, KIND_CH6, KIND_CH4};
    phase_mode = '{MODE_T2, MODE_T3, MODE_T2, MODE_T3, MODE_IDLE0,
                   MODE_IDLE1, MODE_T3, MODE_T3, MODE_T2, MODE_T2};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].op)
        ROW_SET_KIND: begin
          write_register(CFG_DEVICE_KIND, directed_rows[i].word[CFG_DATA_W-1:0]);
        end
        ROW_SET_MODE: begin
          write_register(CFG_TIMING_MODE, directed_rows[i].word[CFG_DATA_W-1:0]);
        end
        default: begin
          send_record(directed_rows[i].word, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);
        end
      endcase
    end

    // Six-bit-channel T2 is still selected: long overflows push the base up
    // in large steps, with photons in between to see wide time tags.
    for (int i = 0; i < LONG_OVF_RECORDS; i++) begin
      w = (i % 16 == 15) ? ($urandom() & 32'h7FFF_FFFF) : 32'hFFFF_FFFF;
      send_record(w, $urandom_range(0, 15) == 0, 1'b0, '0);
    end

    // Random records under each setting, undecoded modes kept short.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(CFG_DEVICE_KIND, {1'($urandom_range(0, 1)), phase_kind[p]});
      write_register(CFG_TIMING_MODE, phase_mode[p]);
      phase_len = (phase_mode[p] == MODE_T2 || phase_mode[p] == MODE_T3) ? 210 : 40;
      for (int i = 0; i < phase_len; i++) begin
        send_record(pick_record(), $urandom_range(0, 15) == 0, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver stall pattern: free stretches, long stalls and random toggling.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall <= 1'b0;
          stall_left <= $urandom_range(20, 120);
        end
        1: begin
          out_stall <= 1'b1;
          stall_left <= $urandom_range(1, 12);
        end
        default: begin
          out_stall <= 1'($urandom_range(0, 1));
          stall_left <= $urandom_range(1, 3);
        end
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Compare each result transfer with the oldest expected result.
  always @(posedge clk) begin
    record_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no record outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("is_photon", 64'(want.is_photon), 64'(is_photon));
        check_field("time_value", want.time_value, time_value);
        check_field("sync_count", want.sync_count, sync_count);
        check_field("channel_number", 64'(want.channel_number), 64'(channel_number));
        check_field("photons_in_buffer", want.photons_in_buffer, photons_in_buffer);
        check_field("overflow_total", want.overflow_total, overflow_total);
      end
    end
  end

  // Watchdog: too long without any transfer on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* filelist.f */
src/ttrd_pkg.sv
src/ttrd_decode.sv
src/ttrd_accum.sv
src/time_tag_record_decoder_unit.sv
tb/time_tag_record_decoder_unit_tb.sv
